// ----- src/dds_pkg.sv -----
// Shared types and constants for the dense shortest-path block.
package dds_pkg;

    localparam int DIST_BITS   = 15;
    localparam int VERTEX_BITS = 4;
    localparam int CFG_BITS    = 5;

    localparam logic [DIST_BITS-1:0] DIST_INF = 15'h7FFF;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef enum logic [0:0] {
        CFG_START_VERTEX = 1'b0,
        CFG_VERTEX_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEL,
        ST_SEL_WAIT,
        ST_MARK,
        ST_REL,
        ST_REL_WAIT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic load_edge;
        logic run_init;
        logic sel_start;
        logic sel_issue;
        logic rel_mark;
        logic rel_issue;
        logic out_issue;
        logic out_load;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic start_ok;
        logic out_free;
    } status_t;

endpackage

// ----- src/dds_controller.sv -----
// Sequencer for load, search rounds and result readout.
module dds_controller #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_kind,
    output logic                              s_tready,
    input  dds_pkg::status_t                  status,
    input  logic [$clog2(MAX_VERTICES)-1:0]   last_idx,
    output dds_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]   idx
);
    import dds_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);

    state_t          state_reg, state_next;
    logic [VW-1:0]   idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_kind == KIND_RUN) begin
                        state_next = ST_INIT;
                    end else begin
                        cmd.load_edge = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                cmd.run_init = 1'b1;
                idx_next     = '0;
                if (status.start_ok) begin
                    cmd.sel_start = 1'b1;
                    state_next    = ST_SEL;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_SEL: begin
                cmd.sel_issue = 1'b1;
                if (idx_reg == last_idx) begin
                    idx_next   = '0;
                    state_next = ST_SEL_WAIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SEL_WAIT: begin
                state_next = ST_MARK;
            end
            ST_MARK: begin
                idx_next = '0;
                if (status.found) begin
                    cmd.rel_mark = 1'b1;
                    state_next   = ST_REL;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_REL: begin
                cmd.rel_issue = 1'b1;
                if (idx_reg == last_idx) begin
                    idx_next   = '0;
                    state_next = ST_REL_WAIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_REL_WAIT: begin
                // last relax write lands here; next round reads after it
                cmd.sel_start = 1'b1;
                state_next    = ST_SEL;
            end
            ST_OUT_RD: begin
                cmd.out_issue = 1'b1;
                state_next    = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (idx_reg == last_idx);
                    if (idx_reg == last_idx) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idx = idx_reg;

endmodule

// ----- src/dds_datapath.sv -----
// Matrix and distance memories, vertex flags, min-select and relax logic, output register.
module dds_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dds_pkg::cmd_t                     cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]   idx,
    input  logic [dds_pkg::VERTEX_BITS-1:0]   s_row,
    input  logic [dds_pkg::VERTEX_BITS-1:0]   s_col,
    input  logic [7:0]                        s_weight,
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [dds_pkg::CFG_BITS-1:0]      cfg_wdata,
    output dds_pkg::status_t                  status,
    output logic [$clog2(MAX_VERTICES)-1:0]   last_idx,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dds_pkg::VERTEX_BITS-1:0]   m_vertex,
    output logic [dds_pkg::DIST_BITS-1:0]     m_distance,
    output logic                              m_has_pred,
    output logic [dds_pkg::VERTEX_BITS-1:0]   m_pred,
    output logic                              m_last
);
    import dds_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [3:0] start_vertex_reg;
    logic [4:0] vertex_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_vertex_reg <= 4'd0;
            vertex_count_reg <= 5'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_VERTEX: start_vertex_reg <= cfg_wdata[3:0];
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (vertex_count_reg == 5'd0) begin
            last_idx = '0;
        end else if (32'(vertex_count_reg) >= MAX_VERTICES) begin
            last_idx = VW'(MAX_VERTICES - 1);
        end else begin
            last_idx = VW'(vertex_count_reg - 5'd1);
        end
    end

    logic          start_ok;
    logic [VW-1:0] start_idx;
    assign start_ok  = (32'(start_vertex_reg) <= 32'(last_idx));
    assign start_idx = VW'(start_vertex_reg);

    // edge matrix, entry [row][col] at row*MAX_VERTICES + col
    logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] edge_rd_reg;
    logic [VW-1:0]          best_idx_reg;
    logic                   load_ok;
    logic [AW-1:0]          load_addr;
    logic [AW-1:0]          rel_addr;

    assign load_ok   = (32'(s_row) < MAX_VERTICES) && (32'(s_col) < MAX_VERTICES);
    assign load_addr = AW'(32'(s_row) * MAX_VERTICES + 32'(s_col));
    assign rel_addr  = AW'(32'(idx) * MAX_VERTICES + 32'(best_idx_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load_edge && load_ok) begin
            edge_mem[load_addr] <= WEIGHT_BITS'(s_weight);
        end
        if (cmd.rel_issue) begin
            edge_rd_reg <= edge_mem[rel_addr];
        end
    end

    // distance / predecessor store; entries not reached read as unreachable
    logic [DIST_BITS-1:0] dist_mem [MAX_VERTICES];
    logic [VW-1:0]        pred_mem [MAX_VERTICES];
    logic [DIST_BITS-1:0] dist_rd_reg;
    logic [VW-1:0]        pred_rd_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [VW-1:0]        wr_addr;
    logic [DIST_BITS-1:0] wr_dist;

    assign rd_en = cmd.sel_issue | cmd.rel_issue | cmd.out_issue;

    // read-side pipeline stage
    logic          p_sel_reg, p_rel_reg;
    logic [VW-1:0] p_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_sel_reg <= 1'b0;
            p_rel_reg <= 1'b0;
        end else begin
            p_sel_reg <= cmd.sel_issue;
            p_rel_reg <= cmd.rel_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            p_idx_reg   <= idx;
            dist_rd_reg <= dist_mem[idx];
            pred_rd_reg <= pred_mem[idx];
        end
        if (wr_en) begin
            dist_mem[wr_addr] <= wr_dist;
            pred_mem[wr_addr] <= best_idx_reg;
        end
    end

    logic [MAX_VERTICES-1:0] fin_reg;
    logic [MAX_VERTICES-1:0] reached_reg;
    logic [MAX_VERTICES-1:0] has_pred_reg;
    logic [DIST_BITS-1:0]    cur_dist;
    logic [DIST_BITS-1:0]    best_dist_reg;
    logic                    found_reg;
    logic [DIST_BITS:0]      sum;
    logic [DIST_BITS-1:0]    sat_sum;
    logic                    relax_wr;
    logic                    sel_take;

    assign cur_dist = reached_reg[p_idx_reg] ? dist_rd_reg : DIST_INF;
    assign sum      = {1'b0, best_dist_reg} + (DIST_BITS+1)'(edge_rd_reg);
    assign sat_sum  = (sum > {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_BITS-1:0];
    assign relax_wr = p_rel_reg && !fin_reg[p_idx_reg] && (edge_rd_reg != '0)
                      && (cur_dist > sat_sum);
    assign sel_take = p_sel_reg && !fin_reg[p_idx_reg]
                      && (!found_reg || (cur_dist < best_dist_reg));

    always_comb begin
        wr_en   = relax_wr;
        wr_addr = p_idx_reg;
        wr_dist = sat_sum;
        if (cmd.run_init) begin
            wr_en   = start_ok;
            wr_addr = start_idx;
            wr_dist = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg      <= '0;
            reached_reg  <= '0;
            has_pred_reg <= '0;
            found_reg    <= 1'b0;
        end else begin
            if (cmd.run_init) begin
                fin_reg      <= '0;
                has_pred_reg <= '0;
                reached_reg  <= start_ok ? (MAX_VERTICES'(1) << start_idx) : '0;
            end
            if (cmd.rel_mark) begin
                fin_reg[best_idx_reg] <= 1'b1;
            end
            if (relax_wr) begin
                reached_reg[p_idx_reg]  <= 1'b1;
                has_pred_reg[p_idx_reg] <= 1'b1;
            end
            if (cmd.sel_start) begin
                found_reg <= 1'b0;
            end else if (sel_take) begin
                found_reg <= 1'b1;
            end
        end
    end

    // first unfinished vertex wins ties: replace only on strictly smaller
    always_ff @(posedge aclk) begin
        if (sel_take) begin
            best_idx_reg  <= p_idx_reg;
            best_dist_reg <= cur_dist;
        end
    end

    // output register
    logic out_valid_reg;
    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_vertex   <= VERTEX_BITS'(p_idx_reg);
            m_distance <= cur_dist;
            m_has_pred <= has_pred_reg[p_idx_reg];
            m_pred     <= has_pred_reg[p_idx_reg] ? VERTEX_BITS'(pred_rd_reg) : '0;
            m_last     <= cmd.out_last;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign status.found    = found_reg;
    assign status.start_ok = start_ok;
    assign status.out_free = out_free;

endmodule

// ----- src/dense_dijkstra_shortest_paths.sv -----
// Top level of the dense single-source shortest-path block.
// Load items (tuser 0) write one adjacency entry per cycle, weight 0 meaning no edge. A run
// item (tuser 1) computes shortest paths from start_vertex over the first vertex_count
// vertices (0 counts as 1, above MAX_VERTICES saturates) and then emits one result per vertex
// in vertex order, tlast on the final one. With n vertices a run is an init step, then n
// rounds of one min-select pass and one relax pass, each one vertex per cycle through the
// single-read-port distance and matrix memories, plus the turnaround states SEL_WAIT, MARK
// and REL_WAIT; then a closing select pass that finds no unfinished vertex, then the result
// readout, where each result is read and then loaded into the output register once that is
// free; if the start vertex is outside the used range only the init step and the readout
// run. Input is not accepted during a run; the next item is taken as soon as the final
// result sits in the output register.
module dense_dijkstra_shortest_paths #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // row[3:0], col[7:4], weight[15:8]
    input  logic        s_tuser,    // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // vertex[3:0], distance[18:4], has_pred[19], pred[23:20]
    output logic        m_tlast
);
    import dds_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);

    cmd_t                    cmd;
    status_t                 status;
    logic [VW-1:0]           idx;
    logic [VW-1:0]           last_idx;
    logic [VERTEX_BITS-1:0]  m_vertex;
    logic [DIST_BITS-1:0]    m_distance;
    logic                    m_has_pred;
    logic [VERTEX_BITS-1:0]  m_pred;

    dds_controller #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .last_idx (last_idx),
        .cmd      (cmd),
        .idx      (idx)
    );

    dds_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .idx        (idx),
        .s_row      (s_tdata[3:0]),
        .s_col      (s_tdata[7:4]),
        .s_weight   (s_tdata[15:8]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .status     (status),
        .last_idx   (last_idx),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_vertex   (m_vertex),
        .m_distance (m_distance),
        .m_has_pred (m_has_pred),
        .m_pred     (m_pred),
        .m_last     (m_tlast)
    );

    assign m_tdata = {m_pred, m_has_pred, m_distance, m_vertex};

    // a result is never loaded over one still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register busy");

    // at most one memory operation is commanded per cycle
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_edge, cmd.run_init, cmd.sel_issue, cmd.rel_issue, cmd.out_issue}))
        else $error("conflicting datapath commands");

    // an accepted run item closes the input
    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_RUN)) |=> !s_tready)
        else $error("input open right after a run item");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the dense shortest-path block against a local path solver.
`timescale 1ns / 1ps

module tb;
    import dds_pkg::*;

    localparam int MAXV        = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic       kind;
        logic [3:0] row;
        logic [3:0] col;
        logic [7:0] weight;
    } graph_item_t;

    typedef struct {
        logic [3:0]           vertex;
        logic [DIST_BITS-1:0] distance;
        logic                 has_pred;
        logic [3:0]           pred;
        logic                 last;
    } vertex_path_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = CFG_START_VERTEX;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // row[3:0], col[7:4], weight[15:8]
    logic        s_tuser   = 1'b0;  // kind[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // vertex[3:0], distance[18:4], has_pred[19], pred[23:20]
    logic        m_tlast;

    dense_dijkstra_shortest_paths DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // local copy of the block's matrix and registers, updated on accepted items/writes
    logic [7:0]  adj_w [MAXV][MAXV];
    logic [3:0]  cfg_start = 4'd0;
    logic [4:0]  cfg_count = 5'd16;
    bit          loaded [MAXV][MAXV];

    graph_item_t  item_q [$];
    vertex_path_t path_q [$];
    graph_item_t  cur_item;
    int           mismatch_cnt = 0;
    int           cycle_cnt    = 0;
    int           in_gap       = 0;
    int           stall_left   = 0;
    bit           calm         = 1'b0;
    int           zero_pct     = 25;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int used_vertices(input logic [4:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > MAXV) return MAXV;
        return int'(cnt);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Dijkstra over the first n vertices; entry [i][sel] relaxes i through sel
    task automatic solve_paths();
        int n, sel, rnd, i, sum;
        logic [DIST_BITS-1:0] path_dist [MAXV];
        logic [3:0] prv [MAXV];
        bit hp [MAXV];
        bit done [MAXV];
        vertex_path_t rec;
        n = used_vertices(cfg_count);
        for (i = 0; i < MAXV; i++) begin
            path_dist[i] = DIST_INF;
            prv[i]  = '0;
            hp[i]   = 1'b0;
            done[i] = 1'b0;
        end
        if (cfg_start < n) begin
            path_dist[cfg_start] = '0;
            for (rnd = 0; rnd < n; rnd++) begin
                sel = 0;
                while (sel < n && done[sel]) sel++;
                if (sel >= n) break;
                for (i = 0; i < n; i++)
                    if (!done[i] && path_dist[sel] > path_dist[i]) sel = i;
                done[sel] = 1'b1;
                for (i = 0; i < n; i++) begin
                    if (!done[i] && adj_w[i][sel] != 0) begin
                        sum = int'(path_dist[sel]) + int'(adj_w[i][sel]);
                        if (sum > int'(DIST_INF)) sum = int'(DIST_INF);
                        if (int'(path_dist[i]) > sum) begin
                            path_dist[i] = sum[DIST_BITS-1:0];
                            prv[i]  = sel[3:0];
                            hp[i]   = 1'b1;
                        end
                    end
                end
            end
        end
        for (i = 0; i < n; i++) begin
            rec.vertex   = i[3:0];
            rec.distance = path_dist[i];
            rec.has_pred = hp[i];
            rec.pred     = hp[i] ? prv[i] : 4'd0;
            rec.last     = (i == n - 1);
            path_q.push_back(rec);
        end
    endtask

    task automatic apply_item(input graph_item_t it);
        if (it.kind == KIND_LOAD) adj_w[it.row][it.col] = it.weight;
        else solve_paths();
    endtask

    // input side: feeds queued items with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            if (s_tvalid && s_tready) apply_item(cur_item);
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    cur_item = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.kind;
                    s_tdata  <= {cur_item.weight, cur_item.col, cur_item.row};
                    in_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result();
        vertex_path_t e;
        if (path_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result tdata=%h last=%b", m_tdata, m_tlast));
            return;
        end
        e = path_q.pop_front();
        if (m_tdata[3:0] !== e.vertex)
            note_mismatch($sformatf("vertex got %0d want %0d", m_tdata[3:0], e.vertex));
        if (m_tdata[18:4] !== e.distance)
            note_mismatch($sformatf("v%0d distance got %0d want %0d",
                                    e.vertex, m_tdata[18:4], e.distance));
        if (m_tdata[19] !== e.has_pred)
            note_mismatch($sformatf("v%0d has_pred got %b want %b",
                                    e.vertex, m_tdata[19], e.has_pred));
        if (m_tdata[23:20] !== e.pred)
            note_mismatch($sformatf("v%0d pred got %0d want %0d",
                                    e.vertex, m_tdata[23:20], e.pred));
        if (m_tlast !== e.last)
            note_mismatch($sformatf("v%0d last got %b want %b", e.vertex, m_tlast, e.last));
    endtask

    // result side: random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap() + 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] rand_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 8'd0;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'($urandom_range(1, 4));   // small weights give ties
        if (r < 45) return 8'd255;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void push_load(input int r, input int c, input logic [7:0] w);
        graph_item_t it;
        it.kind   = KIND_LOAD;
        it.row    = r[3:0];
        it.col    = c[3:0];
        it.weight = w;
        loaded[r][c] = 1'b1;
        item_q.push_back(it);
    endfunction

    // row/col/weight of a run are don't-care; keep them random
    function automatic void push_run();
        graph_item_t it;
        it.kind   = KIND_RUN;
        it.row    = 4'($urandom_range(0, 15));
        it.col    = 4'($urandom_range(0, 15));
        it.weight = 8'($urandom_range(0, 255));
        item_q.push_back(it);
    endfunction

    // never let a run touch a matrix entry that was not written
    function automatic int fill_matrix(input int n);
        int r, c, k;
        k = 0;
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                if (!loaded[r][c]) begin
                    push_load(r, c, rand_weight());
                    k++;
                end
        return k;
    endfunction

    task automatic drain();
        do @(negedge aclk);
        while (item_q.size() != 0 || s_tvalid || path_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(input logic [3:0] start, input logic [4:0] count);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_VERTEX;
        cfg_wdata <= {1'b0, start};
        @(posedge aclk);
        cfg_start = start;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_count = count;
        cfg_we <= 1'b0;
    endtask

    initial begin
        int ph, rand_items, n, nseq, m, k, r, c;
        int start_tab [9];
        int count_tab [9];
        start_tab = '{0, 15, 7, 3, 0, 15, 9, 4, 15};
        count_tab = '{16, 16, 31, 17, 0, 1, 5, 8, 15};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: three-vertex graph, weight extremes, ignored run fields
        set_config(4'd0, 5'd3);
        push_load(0, 0, 8'd0);
        push_load(0, 1, 8'd255);
        push_load(0, 2, 8'd1);
        push_load(1, 0, 8'd1);
        push_load(1, 1, 8'd0);
        push_load(1, 2, 8'd0);
        push_load(2, 0, 8'd7);
        push_load(2, 1, 8'd255);
        push_load(2, 2, 8'd0);
        push_run();
        drain();
        // vertex 1 only reachable through vertex 2
        push_load(1, 0, 8'd0);
        push_load(1, 2, 8'd128);
        push_run();
        drain();
        // start outside the used range: nothing reachable
        set_config(4'd15, 5'd2);
        push_run();
        drain();
        // count zero behaves as one vertex
        set_config(4'd1, 5'd0);
        push_run();
        drain();
        // equal distances: lowest index wins
        set_config(4'd2, 5'd3);
        push_load(0, 2, 8'd5);
        push_load(1, 2, 8'd5);
        push_run();
        drain();

        rand_items = 0;
        ph = 0;
        while (rand_items < 360) begin
            calm = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 2);
            zero_pct = (k == 0) ? 10 : ((k == 1) ? 40 : 80);
            if (ph < 9) begin
                set_config(4'(start_tab[ph]), 5'(count_tab[ph]));
            end else begin
                k = $urandom_range(0, 9);
                if (k < 7) c = $urandom_range(1, 8);
                else if (k < 9) c = $urandom_range(9, 16);
                else c = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
                set_config(4'($urandom_range(0, 15)), 5'(c));
            end
            n = used_vertices(cfg_count);
            rand_items += fill_matrix(n);
            nseq = $urandom_range(2, 5);
            repeat (nseq) begin
                m = $urandom_range(0, 10);
                repeat (m) begin
                    if ($urandom_range(0, 99) < 85) begin
                        r = $urandom_range(0, n - 1);
                        c = $urandom_range(0, n - 1);
                    end else begin
                        r = $urandom_range(0, 15);
                        c = $urandom_range(0, 15);
                    end
                    push_load(r, c, rand_weight());
                end
                push_run();
                rand_items += m + 1;
                if ($urandom_range(0, 9) == 0) begin
                    push_run();
                    rand_items++;
                end
            end
            drain();
            ph++;
        end

        drain();
        repeat (40) @(posedge aclk);
        if (mismatch_cnt == 0 && path_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
